>>> src/sc2a_pkg.sv
// Shared types, scancode constants and the four keymap rows for the
// scancode to ASCII translator. No dependencies.
package sc2a_pkg;

  localparam int CodeW = 8;
  localparam int TableLen = 58;
  localparam int TableIdxW = $clog2(TableLen);

  // Set-1 modifier scancodes.
  localparam logic [CodeW-1:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [CodeW-1:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [CodeW-1:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [CodeW-1:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [CodeW-1:0] SC_CTRL_MAKE    = 8'h1D;
  localparam logic [CodeW-1:0] SC_CTRL_BREAK   = 8'h9D;
  localparam logic [CodeW-1:0] SC_CAPS_MAKE    = 8'h3A;

  localparam logic [CodeW-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CodeW-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CodeW-1:0] CASE_OFFSET  = 8'h20;
  localparam logic [CodeW-1:0] CTRL_OFFSET  = 8'h40;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic caps;
  } mods_t;

  typedef logic [CodeW-1:0] byte_t;

  // Row order: plain, caps lock, shift, shift with caps lock.
  localparam byte_t KEYMAP [4][TableLen] = '{
    '{8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
      8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
      8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h00,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
      8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h20},
    '{8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
      8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
      8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h5B, 8'h5D, 8'h0A, 8'h00,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3B,
      8'h27, 8'h60, 8'h00, 8'h5C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
      8'h4D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h20},
    '{8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
      8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
      8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h00,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
      8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h20},
    '{8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
      8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
      8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h7B, 8'h7D, 8'h0D, 8'h00,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3A,
      8'h22, 8'h7E, 8'h00, 8'h7C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
      8'h6D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h20}
  };

endpackage

>>> src/sc2a_code_if.sv
// Stream interface that carries one scancode byte per beat.
// Depends on sc2a_pkg for the byte type.
interface sc2a_code_if;
  logic             valid;
  logic             ready;
  sc2a_pkg::byte_t  scancode;

  modport source (output valid, output scancode, input ready);
  modport sink (input valid, input scancode, output ready);
endinterface

>>> src/sc2a_char_if.sv
// Stream interface that carries one output byte per beat.
// Depends on sc2a_pkg for the byte type.
interface sc2a_char_if;
  logic             valid;
  logic             ready;
  sc2a_pkg::byte_t  out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink (input valid, input out_byte, output ready);
endinterface

>>> src/scancode_to_ascii_translator.sv
// Top level of the scancode to ASCII translator: input register, modifier
// tracker, keymap lookup and result register. Depends on sc2a_pkg,
// sc2a_code_if, sc2a_char_if, sc2a_modifier_tracker and sc2a_char_map.
//
//   Channel  Dir  Beat payload        Notes
//   codes    in   scancode [7:0]      one set-1 scancode byte
//   chars    out  out_byte [7:0]      zero or one byte per scancode
//   cfg      in   cfg_wdata (1 bit)   raw_mode, written when cfg_we is high
//
// A scancode waits in the input register; the modifier decode and keymap
// lookup sit between that register and the result register, so the
// result register loads as the beat leaves the input register. One beat per
// cycle is sustained while chars does not stall.
// Reset clears the modifier state, raw_mode and both valid flags.
// When chars stalls, the result register holds its byte, the input register
// keeps its byte and codes drops ready once the input register is full.
module scancode_to_ascii_translator (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  sc2a_code_if.sink    codes,
  sc2a_char_if.source  chars
);
  import sc2a_pkg::*;

  logic   raw_mode;

  // Input register.
  logic   stg_valid;
  byte_t  stg_code;

  // Result register.
  logic   out_valid;
  byte_t  out_data;

  logic   advance;
  logic   produce;
  logic   is_mod;
  byte_t  mapped;
  mods_t  mods;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode <= 1'b0;
    end else if (cfg_we) begin
      raw_mode <= cfg_wdata;
    end
  end

  // The staged byte moves on when the result register is free or drains now.
  assign advance     = stg_valid & (~out_valid | chars.ready);
  assign codes.ready = ~stg_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (codes.ready) begin
      stg_valid <= codes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (codes.valid && codes.ready) begin
      stg_code <= codes.scancode;
    end
  end

  sc2a_modifier_tracker u_mods (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .code   (stg_code),
    .mods   (mods),
    .is_mod (is_mod)
  );

  // Lookups only happen for non-modifier codes, so the current modifier
  // state is already the one that applies to this byte.
  sc2a_char_map u_map (
    .code     (stg_code),
    .mods     (mods),
    .is_mod   (is_mod),
    .raw_mode (raw_mode),
    .produce  (produce),
    .out_byte (mapped)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produce) begin
      out_valid <= 1'b1;
    end else if (chars.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      out_data <= mapped;
    end
  end

  assign chars.valid    = out_valid;
  assign chars.out_byte = out_data;

  // An empty input register always takes a new beat.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !stg_valid |-> codes.ready)
    else $error("input register empty but codes not ready");

  // A stalled result holds the staged scancode in place.
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stg_valid && out_valid && !chars.ready |=> stg_valid && $stable(stg_code))
    else $error("staged scancode lost during output stall");

  // Raw mode never swallows a byte.
  a_raw_emits: assert property (@(posedge clk) disable iff (rst)
    advance && raw_mode |=> out_valid)
    else $error("raw mode byte was not emitted");

  // Caps lock flips exactly when its scancode goes through.
  a_caps_toggle: assert property (@(posedge clk) disable iff (rst)
    advance && stg_code == SC_CAPS_MAKE |=> mods.caps != $past(mods.caps))
    else $error("caps lock did not toggle");

  // A modifier in cooked mode produces no result.
  a_mod_silent: assert property (@(posedge clk) disable iff (rst)
    advance && is_mod && !raw_mode |-> !produce)
    else $error("modifier produced a result in cooked mode");
endmodule

>>> src/sc2a_modifier_tracker.sv
// Shift, ctrl and caps-lock state, updated as each scancode leaves the
// input register. Depends on sc2a_pkg.
module sc2a_modifier_tracker (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  sc2a_pkg::byte_t  code,
  output sc2a_pkg::mods_t  mods,
  output logic             is_mod
);
  import sc2a_pkg::*;

  mods_t mods_next;

  always_comb begin
    mods_next = mods;
    is_mod    = 1'b1;
    unique case (code)
      SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:   mods_next.shift = 1'b1;
      SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: mods_next.shift = 1'b0;
      SC_CTRL_MAKE:                     mods_next.ctrl  = 1'b1;
      SC_CTRL_BREAK:                    mods_next.ctrl  = 1'b0;
      SC_CAPS_MAKE:                     mods_next.caps  = ~mods.caps;
      default:                          is_mod          = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mods <= '0;
    end else if (step) begin
      mods <= mods_next;
    end
  end
endmodule

>>> src/sc2a_char_map.sv
// Keymap lookup with ctrl folding, plus the raw pass-through choice.
// Depends on sc2a_pkg for the keymap table and constants.
module sc2a_char_map (
  input  sc2a_pkg::byte_t  code,
  input  sc2a_pkg::mods_t  mods,
  input  logic             is_mod,
  input  logic             raw_mode,
  output logic             produce,
  output sc2a_pkg::byte_t  out_byte
);
  import sc2a_pkg::*;

  logic                 in_table;
  logic [TableIdxW-1:0] idx;
  byte_t                looked;
  byte_t                folded;

  assign in_table = (code < byte_t'(TableLen));
  assign idx      = code[TableIdxW-1:0];

  always_comb begin
    looked = KEYMAP[{mods.shift, mods.caps}][idx];
    folded = looked;
    if (mods.ctrl) begin
      if (looked >= CHAR_LOWER_A && looked <= CHAR_LOWER_Z) begin
        folded = looked - CASE_OFFSET;
      end
      folded = folded - CTRL_OFFSET;
    end
  end

  // Raw mode echoes every byte; cooked mode answers plain codes in the table.
  assign produce  = raw_mode | (~is_mod & in_table);
  assign out_byte = raw_mode ? code : folded;
endmodule

>>> tb/sv/sc2a_checker.sv
// Checker for the scancode to ASCII translator: watches the code, char and
// config ports, predicts each output byte and compares it in order.
// Depends on sc2a_pkg for the byte type, modifier scancodes and offsets.
module sc2a_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  logic            code_valid,
  input  logic            code_ready,
  input  sc2a_pkg::byte_t scancode,
  input  logic            char_valid,
  input  logic            char_ready,
  input  sc2a_pkg::byte_t out_byte,
  output int              fail_count,
  output int              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import sc2a_pkg::*;

  localparam byte_t ENTER_KEY = 8'h1C;
  localparam byte_t LINE_FEED = 8'h0A;

  // Unshifted and shifted key rows. Caps lock flips the case of letters only,
  // except that Enter gives a line feed under caps lock without shift.
  localparam byte_t PLAIN_ROW [TableLen] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h20};
  localparam byte_t SHIFTED_ROW [TableLen] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h20};

  logic  raw_mode;
  mods_t mods;
  byte_t expected_chars [$];
  byte_t want;
  int    mismatches = 0;
  int    queued = 0;

  assign fail_count = mismatches;
  assign outstanding = queued;

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t ns: %s", $realtime, msg);
    end
  endtask

  // Updates the modifier state for one code and queues the byte it yields.
  function automatic void predict_char(input byte_t code);
    byte_t c;
    logic  is_mod;
    is_mod = 1'b1;
    if (raw_mode) begin
      expected_chars.push_back(code);
    end
    case (code)
      SC_LSHIFT_MAKE, SC_RSHIFT_MAKE: mods.shift = 1'b1;
      SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: mods.shift = 1'b0;
      SC_CTRL_MAKE: mods.ctrl = 1'b1;
      SC_CTRL_BREAK: mods.ctrl = 1'b0;
      SC_CAPS_MAKE: mods.caps = ~mods.caps;
      default: is_mod = 1'b0;
    endcase
    if (!raw_mode && !is_mod && code < TableLen) begin
      c = mods.shift ? SHIFTED_ROW[code] : PLAIN_ROW[code];
      if (mods.caps && (c | CASE_OFFSET) >= CHAR_LOWER_A && (c | CASE_OFFSET) <= CHAR_LOWER_Z) begin
        c ^= CASE_OFFSET;
      end
      if (mods.caps && !mods.shift && code == ENTER_KEY) begin
        c = LINE_FEED;
      end
      if (mods.ctrl) begin
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
          c -= CASE_OFFSET;
        end
        c -= CTRL_OFFSET;
      end
      expected_chars.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      raw_mode = 1'b0;
      mods = '0;
      expected_chars.delete();
    end else begin
      if (cfg_we) begin
        raw_mode = cfg_wdata;
      end
      // Results come through both DUT registers, so checking first is safe.
      if (char_valid && char_ready) begin
        if (expected_chars.size() == 0) begin
          report($sformatf("unexpected char beat 0x%02h", out_byte));
        end else begin
          want = expected_chars.pop_front();
          if (out_byte !== want) begin
            report($sformatf("out_byte mismatch: expected 0x%02h, got 0x%02h", want, out_byte));
          end
        end
      end
      if (code_valid && code_ready) begin
        predict_char(scancode);
      end
    end
    queued <= expected_chars.size();
  end

endmodule

>>> tb/sv/tb_scancode_to_ascii_translator.sv
// Top of the scancode to ASCII translator testbench: clock, reset, code
// stimulus, char back-pressure and the verdict. Depends on sc2a_pkg, both
// stream interfaces, the translator and sc2a_checker.
module tb_scancode_to_ascii_translator;
  timeunit 1ns;
  timeprecision 1ps;

  import sc2a_pkg::*;

  localparam int PhaseCount = 8;
  localparam int PhaseBeats = 250;

  // Directed cooked-mode codes: an empty entry, escape, a letter, space,
  // Alt (an empty entry too), Enter, then caps lock so that Enter becomes a
  // line feed and letters go upper case, shift on top of caps lock so that
  // letters fall back to lower case, a shifted digit and slash, ctrl with a
  // letter, with an empty entry and with a digit (both wrap below zero),
  // and finally codes of 58 and above, which give no output at all.
  localparam byte_t COOKED_SEQ [25] = '{
    8'h00, 8'h01, 8'h10, 8'h39, 8'h38, 8'h1C, 8'h3A, 8'h1C, 8'h10, 8'h2A,
    8'h02, 8'h10, 8'h1C, 8'hAA, 8'h3A, 8'h36, 8'h35, 8'hB6, 8'h1D, 8'h1E,
    8'h00, 8'h02, 8'h9D, 8'h3B, 8'hFF};
  // Directed raw-mode codes: both byte extremes and left shift, ctrl and caps lock,
  // which must come through unchanged while still updating the modifier state.
  localparam byte_t RAW_SEQ [12] = '{
    8'h00, 8'hFF, 8'h2A, 8'h10, 8'hAA, 8'h1D, 8'h9D, 8'h3A, 8'h3A, 8'h80,
    8'h7F, 8'h55};

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  bit   calm = 1'b0;
  int   fail_count;
  int   outstanding;

  sc2a_code_if codes_if ();
  sc2a_char_if chars_if ();

  scancode_to_ascii_translator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .codes     (codes_if),
    .chars     (chars_if)
  );

  sc2a_checker checker_inst (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .code_valid  (codes_if.valid),
    .code_ready  (codes_if.ready),
    .scancode    (codes_if.scancode),
    .char_valid  (chars_if.valid),
    .char_ready  (chars_if.ready),
    .out_byte    (chars_if.out_byte),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  // The char side drops ready at random about a fifth of the time, except during
  // the calm stretch, where it always takes a beat.
  initial begin
    chars_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      chars_if.ready <= calm || ($urandom_range(99) >= 20);
    end
  end

  // Offers one code beat and returns at the edge where it is taken. Valid is
  // left high so that beats can follow back to back; the caller or the
  // next call lowers it. Idle gaps come before the beat, so they can land on
  // any phase of the pipeline.
  task automatic send_code(input byte_t code);
    while (!calm && $urandom_range(99) < 20) begin
      codes_if.valid <= 1'b0;
      @(posedge clk);
    end
    codes_if.valid    <= 1'b1;
    codes_if.scancode <= code;
    @(posedge clk);
    while (!codes_if.ready) begin
      @(posedge clk);
    end
  endtask

  // Stops sending and waits until every predicted byte has come out. A code
  // that yields nothing may still sit in the two-stage pipeline at that
  // point, so the task waits longer before the block counts as idle.
  task automatic wait_drained();
    codes_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Writes raw_mode; only ever called while the block is idle.
  task automatic write_raw(input logic value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    byte_t code;
    bit    counted;
    bit    raw_now;
    int    done;
    int    pick;

    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 1'b0;
    codes_if.valid    <= 1'b0;
    codes_if.scancode <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: cooked mode first, then raw mode.
    write_raw(1'b0);
    foreach (COOKED_SEQ[i]) begin
      send_code(COOKED_SEQ[i]);
    end
    wait_drained();
    write_raw(1'b1);
    foreach (RAW_SEQ[i]) begin
      send_code(RAW_SEQ[i]);
    end

    // Random part. The first two phases pin cooked and raw mode; later ones
    // pick the mode at random, and the third runs with no idling at all.
    // Most codes are key presses inside the table and modifier traffic, so
    // the shift, ctrl and caps states are exercised in every combination;
    // key releases and fully random bytes make up the rest. Releases of
    // ordinary keys are ignored in cooked mode and do not count as work.
    for (int p = 0; p < PhaseCount; p++) begin
      wait_drained();
      raw_now = (p < 2) ? p[0] : 1'($urandom_range(1));
      write_raw(raw_now);
      calm = (p == 2);
      done = 0;
      while (done < PhaseBeats) begin
        pick = $urandom_range(99);
        counted = 1'b1;
        if (pick < 50) begin
          code = byte_t'($urandom_range(TableLen - 1));
        end else if (pick < 62) begin
          case ($urandom_range(3))
            0: code = SC_LSHIFT_MAKE;
            1: code = SC_RSHIFT_MAKE;
            2: code = SC_LSHIFT_BREAK;
            default: code = SC_RSHIFT_BREAK;
          endcase
        end else if (pick < 70) begin
          code = $urandom_range(1) ? SC_CTRL_MAKE : SC_CTRL_BREAK;
        end else if (pick < 75) begin
          code = SC_CAPS_MAKE;
        end else if (pick < 88) begin
          code = byte_t'($urandom_range(TableLen - 1)) | 8'h80;
          counted = raw_now;
        end else begin
          code = byte_t'($urandom_range(255));
          counted = raw_now || code < TableLen;
        end
        send_code(code);
        if (counted) begin
          done++;
          // Once per phase the sender holds off until the output is empty.
          if (done == PhaseBeats / 2) begin
            wait_drained();
          end
        end
      end
      calm = 1'b0;
    end

    wait_drained();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      if (outstanding != 0) begin
        $display("%0d predicted bytes never came out", outstanding);
      end
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest correct run needs.
  initial begin
    #(5_000_000);
    $display("watchdog expired with %0d bytes outstanding", outstanding);
    $display("TEST FAILED");
    $finish;
  end

endmodule
